[src/fsat_pkg.sv]
// Shared types and codes of the fragment send and acknowledge tracker.
package fsat_pkg;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_GET   = 2'd1,
		OP_ACK   = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef enum logic {
		CFG_MTU    = 1'b0,
		CFG_RESEND = 1'b1
	} cfg_index_t;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_FRAME,
		S_GRD,
		S_GCHK,
		S_GLEN,
		S_SIMPLE
	} state_t;

	typedef struct packed {
		logic        found;
		logic [7:0]  sent_part;
		logic [23:0] byte_offset;
		logic [16:0] part_length;
		logic        all_acked;
		logic [7:0]  part_count;
		logic        overflow;
	} result_t;

	localparam logic [23:0] FS_MAX    = 24'hFFFFFF;
	localparam logic [15:0] MTU_RESET = 16'd500;
	localparam logic [31:0] RI_RESET  = 32'd1000;

endpackage

[src/fsat_ram.sv]
// Generic single-port-write, registered-read RAM.
module fsat_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[src/fsat_alu.sv]
// Shared 32-bit add/subtract unit with a carry or borrow bit.
module fsat_alu import fsat_pkg::*; (
	input  alu_op_t     op,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [32:0] y
);

	always_comb begin
		unique case (op)
			ALU_ADD: y = {1'b0, a} + {1'b0, b};
			ALU_SUB: y = {1'b0, a} - {1'b0, b};
			default: y = '0;
		endcase
	end

endmodule

[src/fragment_send_ack_tracker.sv]
// Top level of the fragment send and acknowledge tracker: sequencer and state.
//
// Channel   Direction  Handshake             Fields
// command   in         start & !busy         opcode, payload_length, now_time,
//                                            resend_mode, part_number
// result    out        done (one cycle)      found, sent_part, byte_offset,
//                                            part_length, all_acked,
//                                            part_count, overflow
// config    in         cfg_we                cfg_index, cfg_data
//
// Steps: start finds the part count by adding the MTU once per cycle in the
// shared adder, then forms the framed size. Get examines parts in turn: a stamp
// memory read, then the age compare in the shared adder, and for the part it
// picks a length step. Acknowledge and the unused opcode use S_SIMPLE.
// The result word appears in the cycle after the final state, while busy is already low again.
// Reset clears all tracking state at once; the stamp memory is guarded by
// per-entry valid bits, so there is no clearing pass. The receiver cannot
// stall: done is high for a single cycle per result word.
module fragment_send_ack_tracker import fsat_pkg::*; #(
	parameter int MAX_PARTS    = 64,
	parameter int HEADER_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [23:0] payload_length,
	input  logic [31:0] now_time,
	input  logic        resend_mode,
	input  logic [7:0]  part_number,
	output logic        done,
	output logic        found,
	output logic [7:0]  sent_part,
	output logic [23:0] byte_offset,
	output logic [16:0] part_length,
	output logic        all_acked,
	output logic [7:0]  part_count,
	output logic        overflow,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	// Index width into per-part storage, and counter width that can hold MAX_PARTS.
	localparam int IW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
	localparam int CW = $clog2(MAX_PARTS + 1);

	// Configuration registers.
	logic [15:0] mtu_q;
	logic [31:0] interval_q;

	// Control and tracking state.
	state_t               state_q, state_d;
	logic [7:0]           total_q, total_d;
	logic [7:0]           unacked_q, unacked_d;
	logic [23:0]          fs_q, fs_d;
	logic [MAX_PARTS-1:0] part_done_q, part_done_d;
	logic [MAX_PARTS-1:0] stamp_valid_q, stamp_valid_d;
	logic                 done_q, fin;

	// Latched command and working registers.
	opcode_t     op_q, op_d;
	logic [23:0] len_q, len_d;
	logic [31:0] now_q, now_d;
	logic        resend_q, resend_d;
	logic [7:0]  pnum_q, pnum_d;
	logic [24:0] acc_q, acc_d;
	logic [CW-1:0] k_q, k_d;
	logic [CW-1:0] i_q, i_d;
	logic [24:0] off_q, off_d;
	result_t     res_q, res_d;

	// Shared adder.
	alu_op_t     alu_op;
	logic [31:0] alu_a, alu_b;
	logic [32:0] alu_y;

	// Stamp memory ports.
	logic          ram_we;
	logic [IW-1:0] ram_addr;
	logic [31:0]   ram_rdata;

	// Derived values.
	logic [15:0] mtu_eff;
	logic [16:0] stride;
	logic [IW-1:0] idx;
	logic [7:0]  pidx;
	logic [31:0] stamp;
	logic [24:0] pay;
	logic [15:0] hdr_sum;
	logic [24:0] rest;
	logic        pick;
	logic        ack_ok;

	fsat_alu u_alu (
		.op (alu_op),
		.a  (alu_a),
		.b  (alu_b),
		.y  (alu_y)
	);

	fsat_ram #(
		.WIDTH (32),
		.DEPTH (MAX_PARTS)
	) u_stamp_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_addr),
		.wdata (now_q),
		.raddr (ram_addr),
		.rdata (ram_rdata)
	);

	// A zero MTU setting counts as one byte per part.
	assign mtu_eff = (mtu_q == 16'd0) ? 16'd1 : mtu_q;
	assign stride  = {1'b0, mtu_eff} + 17'(HEADER_BYTES);
	assign idx     = i_q[IW-1:0];
	assign pidx    = pnum_q - 8'd1;
	// A stamp never written since the last start or reset reads as zero.
	assign stamp   = stamp_valid_q[idx] ? ram_rdata : 32'd0;
	assign pay     = (acc_q < {1'b0, len_q}) ? acc_q : {1'b0, len_q};
	assign hdr_sum = 16'(k_q) * 16'(HEADER_BYTES);
	assign rest    = alu_y[24:0];

	always_comb begin
		state_d       = state_q;
		total_d       = total_q;
		unacked_d     = unacked_q;
		fs_d          = fs_q;
		part_done_d   = part_done_q;
		stamp_valid_d = stamp_valid_q;
		op_d          = op_q;
		len_d         = len_q;
		now_d         = now_q;
		resend_d      = resend_q;
		pnum_d        = pnum_q;
		acc_d         = acc_q;
		k_d           = k_q;
		i_d           = i_q;
		off_d         = off_q;
		res_d         = '0;
		res_d.part_count = total_q;
		fin           = 1'b0;
		alu_op        = ALU_ADD;
		alu_a         = 32'd0;
		alu_b         = 32'd0;
		ram_we        = 1'b0;
		ram_addr      = idx;
		pick          = 1'b0;
		ack_ok        = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					op_d     = opcode_t'(opcode);
					len_d    = payload_length;
					now_d    = now_time;
					resend_d = resend_mode;
					pnum_d   = part_number;
					unique case (opcode_t'(opcode))
						OP_START: begin
							part_done_d   = '0;
							stamp_valid_d = '0;
							acc_d         = 25'd0;
							k_d           = '0;
							state_d       = S_DIV;
						end
						OP_GET: begin
							i_d     = '0;
							off_d   = 25'd0;
							state_d = S_GRD;
						end
						default: state_d = S_SIMPLE;
					endcase
				end
			end

			// Add the MTU until the covered bytes reach the length or the cap is hit.
			S_DIV: begin
				if (acc_q >= {1'b0, len_q} || k_q == CW'(MAX_PARTS)) begin
					state_d = S_FRAME;
				end else begin
					alu_op = ALU_ADD;
					alu_a  = 32'(acc_q);
					alu_b  = 32'(mtu_eff);
					acc_d  = alu_y[24:0];
					k_d    = k_q + CW'(1);
				end
			end

			// Framed size is the covered payload plus one header per part.
			S_FRAME: begin
				alu_op    = ALU_ADD;
				alu_a     = 32'(pay);
				alu_b     = 32'(hdr_sum);
				fs_d      = (alu_y > 33'(FS_MAX)) ? FS_MAX : alu_y[23:0];
				total_d   = 8'(k_q);
				unacked_d = 8'(k_q);
				res_d.part_count = 8'(k_q);
				res_d.overflow   = acc_q < {1'b0, len_q};
				fin       = 1'b1;
				state_d   = S_IDLE;
			end

			// Issue the stamp read for part i, or report that nothing is sendable.
			S_GRD: begin
				if (8'(i_q) >= total_q) begin
					fin     = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_GCHK;
				end
			end

			// Age of the stamp is a wrapping 32-bit difference from the adder.
			S_GCHK: begin
				alu_op = ALU_SUB;
				alu_a  = now_q;
				alu_b  = stamp;
				pick   = !part_done_q[idx] &&
					(resend_q ? (alu_y[31:0] >= interval_q) : (stamp == 32'd0));
				if (pick) begin
					if (resend_q) begin
						ram_we             = 1'b1;
						stamp_valid_d[idx] = 1'b1;
					end else begin
						part_done_d[idx] = 1'b1;
					end
					state_d = S_GLEN;
				end else begin
					i_d     = i_q + CW'(1);
					off_d   = off_q + 25'(stride);
					state_d = S_GRD;
				end
			end

			// The last part may be shorter than a full stride.
			S_GLEN: begin
				alu_op = ALU_SUB;
				alu_a  = 32'(fs_q);
				alu_b  = 32'(off_q);
				res_d.found       = 1'b1;
				res_d.sent_part   = 8'(i_q) + 8'd1;
				res_d.byte_offset = off_q[23:0];
				if ({1'b0, fs_q} > off_q) begin
					res_d.part_length = (rest < 25'(stride)) ? rest[16:0] : stride;
				end
				fin     = 1'b1;
				state_d = S_IDLE;
			end

			// Acknowledge, or the unused opcode which changes nothing.
			S_SIMPLE: begin
				if (op_q == OP_ACK) begin
					ack_ok = pnum_q != 8'd0 && pnum_q <= total_q && unacked_q != 8'd0 &&
						!part_done_q[pidx[IW-1:0]];
					if (ack_ok) begin
						part_done_d[pidx[IW-1:0]] = 1'b1;
						unacked_d       = unacked_q - 8'd1;
						res_d.found     = 1'b1;
						res_d.all_acked = unacked_q == 8'd1;
					end
				end
				fin     = 1'b1;
				state_d = S_IDLE;
			end

			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			total_q       <= 8'd0;
			unacked_q     <= 8'd0;
			fs_q          <= 24'd0;
			part_done_q   <= '0;
			stamp_valid_q <= '0;
			done_q        <= 1'b0;
			mtu_q         <= MTU_RESET;
			interval_q    <= RI_RESET;
		end else begin
			state_q       <= state_d;
			total_q       <= total_d;
			unacked_q     <= unacked_d;
			fs_q          <= fs_d;
			part_done_q   <= part_done_d;
			stamp_valid_q <= stamp_valid_d;
			done_q        <= fin;
			if (cfg_we) begin
				unique case (cfg_index_t'(cfg_index))
					CFG_MTU:    mtu_q      <= cfg_data[15:0];
					CFG_RESEND: interval_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Working registers and the result word carry no reset.
	always_ff @(posedge clk) begin
		op_q     <= op_d;
		len_q    <= len_d;
		now_q    <= now_d;
		resend_q <= resend_d;
		pnum_q   <= pnum_d;
		acc_q    <= acc_d;
		k_q      <= k_d;
		i_q      <= i_d;
		off_q    <= off_d;
		if (fin) begin
			res_q <= res_d;
		end
	end

	assign busy        = state_q != S_IDLE;
	assign done        = done_q;
	assign found       = res_q.found;
	assign sent_part   = res_q.sent_part;
	assign byte_offset = res_q.byte_offset;
	assign part_length = res_q.part_length;
	assign all_acked   = res_q.all_acked;
	assign part_count  = res_q.part_count;
	assign overflow    = res_q.overflow;

endmodule

[verif/fragment_send_ack_tracker_test.sv]
// Self-checking testbench for the fragment send and acknowledge tracker.
`timescale 1ns / 1ps

module fragment_send_ack_tracker_test;
	import fsat_pkg::*;

	// Behavioral copy of the tracker. It keeps its own registers and per-part
	// state, predicts one reply word per accepted command and checks the
	// words that the block returns, oldest first.
	class send_tracker_model;
		localparam int PART_SLOTS = 64;
		localparam int HEADER_LEN = 8;

		bit [15:0] mtu_reg;
		bit [31:0] resend_gap;
		bit [31:0] stamp [PART_SLOTS];
		bit        retired [PART_SLOTS];
		bit [7:0]  parts_total;
		bit [7:0]  parts_open;
		bit [23:0] framed_len;
		result_t   replies_due [$];
		int        mismatch_count;
		int        reply_index;

		function new();
			mtu_reg = MTU_RESET;
			resend_gap = RI_RESET;
			parts_total = '0;
			parts_open = '0;
			framed_len = '0;
			mismatch_count = 0;
			reply_index = 0;
			foreach (stamp[i]) begin
				stamp[i] = '0;
				retired[i] = 1'b0;
			end
		endfunction

		function longint unsigned live_mtu();
			return (mtu_reg == 16'd0) ? 64'd1 : 64'(mtu_reg);
		endfunction

		function void predict_reply(opcode_t op, bit [23:0] len, bit [31:0] now,
				bit resend, bit [7:0] pnum);
			result_t r;
			longint unsigned mtu, cnt, pay, fs, stride, off, rest;
			bit [31:0] age;
			bit pick;
			int slot;
			r = '0;
			mtu = live_mtu();
			stride = mtu + 64'(HEADER_LEN);
			case (op)
				OP_START: begin
					cnt = (64'(len) + mtu - 64'd1) / mtu;
					if (cnt > 64'(PART_SLOTS)) begin
						cnt = 64'(PART_SLOTS);
						r.overflow = 1'b1;
					end
					pay = cnt * mtu;
					if (64'(len) < pay)
						pay = 64'(len);
					fs = pay + cnt * 64'(HEADER_LEN);
					if (fs > 64'(FS_MAX))
						fs = 64'(FS_MAX);
					parts_total = 8'(cnt);
					parts_open = 8'(cnt);
					framed_len = 24'(fs);
					foreach (stamp[i]) begin
						stamp[i] = '0;
						retired[i] = 1'b0;
					end
				end
				OP_GET: begin
					slot = -1;
					for (int i = 0; i < parts_total && i < PART_SLOTS; i++) begin
						if (!retired[i] && slot < 0) begin
							age = now - stamp[i];
							pick = resend ? (age >= resend_gap) : (stamp[i] == 32'd0);
							if (pick)
								slot = i;
						end
					end
					if (slot >= 0) begin
						off = 64'(slot) * stride;
						if (resend)
							stamp[slot] = now;
						else
							retired[slot] = 1'b1;
						r.found = 1'b1;
						r.sent_part = 8'(slot + 1);
						r.byte_offset = 24'(off);
						if (64'(framed_len) > off) begin
							rest = 64'(framed_len) - off;
							r.part_length = 17'((rest < stride) ? rest : stride);
						end
					end
				end
				OP_ACK: begin
					if (pnum >= 1 && pnum <= parts_total && pnum <= PART_SLOTS &&
							parts_open > 0 && !retired[pnum - 1]) begin
						retired[pnum - 1] = 1'b1;
						parts_open--;
						r.found = 1'b1;
						r.all_acked = (parts_open == 8'd0);
					end
				end
				default: begin
				end
			endcase
			r.part_count = parts_total;
			replies_due.push_back(r);
		endfunction

		task report_mismatch(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			mismatch_count++;
		endtask

		task compare_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report_mismatch($sformatf("reply %0d field %s is %0d, expected %0d",
					reply_index, name, got, want));
		endtask

		task check_reply(result_t got);
			result_t want;
			if (replies_due.size() == 0) begin
				report_mismatch($sformatf("reply %0d arrived with no command outstanding",
					reply_index));
			end else begin
				want = replies_due.pop_front();
				compare_field("found", 32'(got.found), 32'(want.found));
				compare_field("sent_part", 32'(got.sent_part), 32'(want.sent_part));
				compare_field("byte_offset", 32'(got.byte_offset), 32'(want.byte_offset));
				compare_field("part_length", 32'(got.part_length), 32'(want.part_length));
				compare_field("all_acked", 32'(got.all_acked), 32'(want.all_acked));
				compare_field("part_count", 32'(got.part_count), 32'(want.part_count));
				compare_field("overflow", 32'(got.overflow), 32'(want.overflow));
			end
			reply_index++;
		endtask
	endclass

	// A correct block never goes this long without taking a command or
	// returning a word: the longest operation is a get that walks all 64
	// parts, and sender gaps are short.
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 140;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  opcode = OP_NONE;
	logic [23:0] payload_length = '0;
	logic [31:0] now_time = '0;
	logic        resend_mode = 1'b0;
	logic [7:0]  part_number = '0;
	logic        done;
	logic        found;
	logic [7:0]  sent_part;
	logic [23:0] byte_offset;
	logic [16:0] part_length;
	logic        all_acked;
	logic [7:0]  part_count;
	logic        overflow;
	logic        cfg_we = 1'b0;
	logic        cfg_index = CFG_MTU;
	logic [31:0] cfg_data = '0;

	send_tracker_model model = new();
	result_t seen_word;
	int stall_cycles = 0;
	int idle_pct = 25;

	fragment_send_ack_tracker uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.opcode        (opcode),
		.payload_length(payload_length),
		.now_time      (now_time),
		.resend_mode   (resend_mode),
		.part_number   (part_number),
		.done          (done),
		.found         (found),
		.sent_part     (sent_part),
		.byte_offset   (byte_offset),
		.part_length   (part_length),
		.all_acked     (all_acked),
		.part_count    (part_count),
		.overflow      (overflow),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	// Monitor. Everything is sampled at the rising edge, before the block's
	// own updates of that edge land. A returned word is checked before a
	// command taken at the same edge is predicted, so a stray word can never
	// be matched against the expectation of the command that follows it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				seen_word.found = found;
				seen_word.sent_part = sent_part;
				seen_word.byte_offset = byte_offset;
				seen_word.part_length = part_length;
				seen_word.all_acked = all_acked;
				seen_word.part_count = part_count;
				seen_word.overflow = overflow;
				model.check_reply(seen_word);
			end
			if (start && !busy)
				model.predict_reply(opcode_t'(opcode), payload_length, now_time,
					resend_mode, part_number);
			if ((start && !busy) || done)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
		end
	end

	// Watchdog: the run is declared broken if the block stops moving.
	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	// Presents one command word. Inputs change only at the falling edge. The
	// sender may first sit idle for a random number of cycles; then start is
	// held until a rising edge sees busy low. The task returns at the next
	// falling edge with start still high, so the caller either presents the
	// next word or lowers start in that same step, never both.
	task automatic issue_command(opcode_t op, bit [23:0] len, bit [31:0] now,
			bit resend, bit [7:0] pnum);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		payload_length <= len;
		now_time <= now;
		resend_mode <= resend;
		part_number <= pnum;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Lowers start and waits until every predicted word has come back. Each
	// command returns exactly one word, so the block is idle afterwards.
	task automatic settle();
		start <= 1'b0;
		do
			@(negedge clk);
		while (model.replies_due.size() != 0 || busy);
	endtask

	// Writes the MTU register and then the resend interval register while the block is idle.
	// The model takes the new values at once since no command is in flight.
	task automatic apply_setting(bit [15:0] mtu, bit [31:0] gap);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= CFG_MTU;
		cfg_data <= {16'd0, mtu};
		model.mtu_reg = mtu;
		@(negedge clk);
		cfg_index <= CFG_RESEND;
		cfg_data <= gap;
		model.resend_gap = gap;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Time advance for resend gets, chosen so that part ages land below,
	// exactly on and just past the resend interval as well as anywhere.
	function automatic bit [31:0] time_step();
		case ($urandom_range(4))
			0: return 32'd0;
			1: return $urandom_range(0, model.resend_gap);
			2: return model.resend_gap;
			3: return model.resend_gap + 32'd1;
			default: return $urandom();
		endcase
	endfunction

	// Random traffic. Most of it is datagram sessions: a start sized to give
	// a chosen part count, then a mix of timed resends, plain sends and
	// acknowledges of live parts, with a few broken acknowledges. The rest
	// is noise with every field random, the unused opcode included.
	task automatic random_traffic(int unsigned words);
		int unsigned issued, parts, live, ops, sel;
		longint unsigned mtu, len;
		bit [31:0] clock_now;
		bit [7:0] pnum;
		issued = 0;
		while (issued < words) begin
			if ($urandom_range(9) < 2) begin
				issue_command(opcode_t'($urandom_range(3)), 24'($urandom()), $urandom(),
					1'($urandom_range(1)), 8'($urandom()));
				issued++;
			end else begin
				mtu = model.live_mtu();
				sel = $urandom_range(99);
				if (sel < 70)
					parts = $urandom_range(1, 6);
				else if (sel < 85)
					parts = $urandom_range(7, 63);
				else if (sel < 92)
					parts = 64;
				else if (sel < 97)
					parts = 65;
				else
					parts = 0;
				// More than 64 parts requested: the block must clamp.
				if (parts == 0)
					len = 64'd0;
				else if (parts <= 64)
					len = 64'(parts - 1) * mtu + 64'($urandom_range(1, 32'(mtu)));
				else
					len = 64'd64 * mtu + 64'($urandom_range(1, 1 << 20));
				if (len > 64'hFFFFFF)
					len = 64'hFFFFFF;
				live = (parts > 64) ? 64 : parts;
				issue_command(OP_START, 24'(len), $urandom(), 1'($urandom_range(1)),
					8'($urandom()));
				issued++;
				ops = $urandom_range(2, 3 * live + 4);
				clock_now = $urandom_range(1) ? $urandom() : $urandom_range(0, 100);
				for (int k = 0; k < ops && issued < words; k++) begin
					sel = $urandom_range(99);
					if (sel < 40) begin
						clock_now += time_step();
						issue_command(OP_GET, 24'($urandom()), clock_now, 1'b1, 8'($urandom()));
					end else if (sel < 55) begin
						issue_command(OP_GET, 24'($urandom()), $urandom(), 1'b0, 8'($urandom()));
					end else if (sel < 90) begin
						if (live == 0 || $urandom_range(9) == 0)
							pnum = 8'($urandom_range(0, 255));
						else
							pnum = 8'($urandom_range(1, live));
						issue_command(OP_ACK, 24'($urandom()), $urandom(),
							1'($urandom_range(1)), pnum);
					end else begin
						// Same time again: parts just stamped are too young.
						issue_command(OP_GET, 24'($urandom()), clock_now, 1'b1, 8'($urandom()));
					end
					issued++;
				end
			end
		end
	endtask

	initial begin
		repeat (4)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part at the reset register values (500 bytes, interval 1000).
		// Commands before any datagram exists find nothing and are rejected.
		issue_command(OP_GET, 24'd0, 32'd5000, 1'b1, 8'd0);
		issue_command(OP_ACK, 24'd0, 32'd0, 1'b0, 8'd1);
		issue_command(OP_NONE, 24'd0, 32'd0, 1'b0, 8'd0);
		// An empty payload gives zero parts.
		issue_command(OP_START, 24'd0, 32'd0, 1'b0, 8'd0);
		issue_command(OP_GET, 24'd0, 32'd0, 1'b0, 8'd0);
		// Three parts, the last one short. Timed resends: a fresh stamp is
		// too young and an old one qualifies.
		issue_command(OP_START, 24'd1200, 32'd0, 1'b0, 8'd0);
		issue_command(OP_GET, 24'd0, 32'd0, 1'b1, 8'd0);
		issue_command(OP_GET, 24'd0, 32'd1000, 1'b1, 8'd0);
		issue_command(OP_GET, 24'd0, 32'd1000, 1'b1, 8'd0);
		issue_command(OP_GET, 24'd0, 32'hFFFFFFFF, 1'b1, 8'd0);
		// Acknowledges out of range, twice for one part, then completion.
		issue_command(OP_ACK, 24'd0, 32'd0, 1'b0, 8'd0);
		issue_command(OP_ACK, 24'd0, 32'd0, 1'b0, 8'd4);
		issue_command(OP_ACK, 24'd0, 32'd0, 1'b0, 8'd2);
		issue_command(OP_ACK, 24'd0, 32'd0, 1'b0, 8'd1);
		issue_command(OP_ACK, 24'd0, 32'd0, 1'b0, 8'd2);
		issue_command(OP_ACK, 24'd0, 32'd0, 1'b0, 8'd3);
		issue_command(OP_GET, 24'd0, 32'hFFFFFFFF, 1'b1, 8'd0);
		// Send-once mode retires each part it hands out.
		issue_command(OP_START, 24'd1200, 32'd0, 1'b0, 8'd0);
		repeat (4)
			issue_command(OP_GET, 24'd0, 32'd0, 1'b0, 8'd0);
		issue_command(OP_ACK, 24'd0, 32'd0, 1'b0, 8'd1);
		// Largest payload overflows the part limit.
		issue_command(OP_START, 24'hFFFFFF, 32'hFFFFFFFF, 1'b1, 8'hFF);
		issue_command(OP_ACK, 24'hFFFFFF, 32'hFFFFFFFF, 1'b1, 8'd255);
		issue_command(OP_ACK, 24'd0, 32'd0, 1'b0, 8'd64);
		issue_command(OP_GET, 24'hFFFFFF, 32'd0, 1'b1, 8'hFF);
		issue_command(OP_NONE, 24'hFFFFFF, 32'hFFFFFFFF, 1'b1, 8'hFF);

		// Random part over several register settings. The sender idles a
		// quarter of the time, then most of the time, then never.
		apply_setting(16'd1, 32'd0);
		random_traffic(250);
		apply_setting(16'hFFFF, 32'hFFFFFFFF);
		random_traffic(250);
		idle_pct = 73;
		apply_setting(16'd0, 32'd5);
		random_traffic(250);
		apply_setting(16'($urandom_range(2, 1500)), $urandom_range(0, 5000));
		random_traffic(250);
		idle_pct = 0;
		apply_setting(16'd8, 32'd1);
		random_traffic(250);
		apply_setting(16'($urandom_range(1, 65535)), $urandom());
		random_traffic(250);

		// Let everything drain, then watch a while longer for stray words.
		settle();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (model.mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
